[rtl/core/nam_pkg.sv]
// ----------------------------------------------------------------------------
// nam_pkg: shared definitions for the non-power-of-two address mirror
// Region codes, configuration register indexes and the control word that
// travels down the fold chain alongside each item.
// ----------------------------------------------------------------------------
`default_nettype none

package nam_pkg;

	// Width of a size register
	localparam int SIZE_W = 25;
	// Default address width
	localparam int ADDRESS_BITS_DEF = 24;
	// Configuration register index width
	localparam int CFG_IDX_W = 2;

	typedef logic [1:0] region_t;

	localparam region_t REGION_RAM  = 2'd0;
	localparam region_t REGION_ROM  = 2'd1;
	localparam region_t REGION_NONE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_RAM_SIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROM_SIZE = 2'd1;

	typedef struct packed {
		logic    valid;
		region_t region;
	} ctl_t;

endpackage

`default_nettype wire

[rtl/core/nam_cell.sv]
// ----------------------------------------------------------------------------
// nam_cell: one bit position of the address fold
// Strips its bit from the address when the address is not below the size,
// and then, if the size exceeds the bit weight, shrinks the size and grows
// the base; it registers the result for the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module nam_cell #(
	parameter int IW  = 26,
	parameter int BIT = 0
) (
	input  wire           clk,
	input  wire           arst_n,
	input  nam_pkg::ctl_t ctl_prev,
	input  wire  [IW-1:0] a_prev,
	input  wire  [IW-1:0] size_prev,
	input  wire  [IW-1:0] base_prev,
	output nam_pkg::ctl_t ctl_next,
	output logic [IW-1:0] a_next,
	output logic [IW-1:0] size_next,
	output logic [IW-1:0] base_next
);
	import nam_pkg::*;

	localparam logic [IW-1:0] WEIGHT = {{(IW-1){1'b0}}, 1'b1} << BIT;

	ctl_t          ctl_q;
	logic [IW-1:0] a_q;
	logic [IW-1:0] size_q;
	logic [IW-1:0] base_q;
	logic [IW-1:0] a_d;
	logic [IW-1:0] size_d;
	logic [IW-1:0] base_d;
	logic          strip;

	always_comb begin
		strip  = (a_prev >= size_prev) && a_prev[BIT];
		a_d    = a_prev;
		size_d = size_prev;
		base_d = base_prev;
		if (strip) begin
			a_d[BIT] = 1'b0;
			// base only ever collects distinct, descending bits: OR is the add
			if (size_prev > WEIGHT) begin
				size_d      = size_prev - WEIGHT;
				base_d[BIT] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q <= ctl_prev;
		end
	end

	always_ff @(posedge clk) begin
		a_q    <= a_d;
		size_q <= size_d;
		base_q <= base_d;
	end

	assign ctl_next  = ctl_q;
	assign a_next    = a_q;
	assign size_next = size_q;
	assign base_next = base_q;

endmodule

`default_nettype wire

[rtl/core/nonpow2_address_mirror.sv]
// ----------------------------------------------------------------------------
// nonpow2_address_mirror: fold a bus address into a non-power-of-two memory
// Selects RAM, else ROM, else none, and mirrors the address onto the size of
// the selected store through a chain of one fold cell per address bit.
// ----------------------------------------------------------------------------
`default_nettype none

// Usage: an item is taken at every clock edge where start is high; busy is
// never raised, so one address can be issued every cycle. Each result comes
// back in order as a one-cycle done strobe with offset and region; the
// receiver must take it in that cycle, there is no way to hold it off. Each
// result passes through the fold chain (one registered cell per address bit,
// most significant first) and then the output register that adds base and
// remaining address. Write ram_size (index 0) and rom_size (index 1) only
// while no item is in flight; cfg_ready is always high and writes to other
// indexes are dropped. With no region present the fold runs against a size
// of zero, which strips every bit, so the offset comes out as zero.

module nonpow2_address_mirror #(
	parameter int ADDRESS_BITS = nam_pkg::ADDRESS_BITS_DEF
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            start,
	output logic                           busy,
	input  wire  [ADDRESS_BITS-1:0]        address,
	output logic                           done,
	output logic [ADDRESS_BITS-1:0]        offset,
	output nam_pkg::region_t               region,
	input  wire                            cfg_valid,
	output logic                           cfg_ready,
	input  wire  [nam_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire  [nam_pkg::SIZE_W-1:0]     cfg_data
);
	import nam_pkg::*;

	// Internal width holds both address and size with one spare bit
	localparam int IW = ((ADDRESS_BITS > SIZE_W) ? ADDRESS_BITS : SIZE_W) + 1;

	logic [SIZE_W-1:0] ram_size_q;
	logic [SIZE_W-1:0] rom_size_q;

	// Configuration: always ready, drop writes past the register list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_size_q <= '0;
			rom_size_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_RAM_SIZE: ram_size_q <= cfg_data;
				CFG_ROM_SIZE: rom_size_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	// Chain taps: index 0 is the entry, index ADDRESS_BITS the last cell
	ctl_t          ctl_c  [0:ADDRESS_BITS];
	logic [IW-1:0] a_c    [0:ADDRESS_BITS];
	logic [IW-1:0] size_c [0:ADDRESS_BITS];
	logic [IW-1:0] base_c [0:ADDRESS_BITS];
	logic [SIZE_W-1:0] sel_size;
	region_t           sel_region;

	// Pick the store: RAM wins, then ROM, else none with size zero
	always_comb begin
		priority if (ram_size_q != '0) begin
			sel_size   = ram_size_q;
			sel_region = REGION_RAM;
		end else if (rom_size_q != '0) begin
			sel_size   = rom_size_q;
			sel_region = REGION_ROM;
		end else begin
			sel_size   = '0;
			sel_region = REGION_NONE;
		end
	end

	assign ctl_c[0].valid  = start & ~busy;
	assign ctl_c[0].region = sel_region;
	assign a_c[0]          = {{(IW-ADDRESS_BITS){1'b0}}, address};
	assign size_c[0]       = {{(IW-SIZE_W){1'b0}}, sel_size};
	assign base_c[0]       = '0;

	// One cell per address bit, from the top bit down
	for (genvar k = 0; k < ADDRESS_BITS; k++) begin : g_cell
		nam_cell #(
			.IW  (IW),
			.BIT (ADDRESS_BITS - 1 - k)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl_prev  (ctl_c[k]),
			.a_prev    (a_c[k]),
			.size_prev (size_c[k]),
			.base_prev (base_c[k]),
			.ctl_next  (ctl_c[k+1]),
			.a_next    (a_c[k+1]),
			.size_next (size_c[k+1]),
			.base_next (base_c[k+1])
		);
	end

	// Output register: offset is base plus what is left of the address
	logic [IW-1:0]           sum;
	logic                    done_q;
	logic [ADDRESS_BITS-1:0] offset_q;
	region_t                 region_q;

	assign sum = base_c[ADDRESS_BITS] + a_c[ADDRESS_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl_c[ADDRESS_BITS].valid;
		end
	end

	always_ff @(posedge clk) begin
		offset_q <= sum[ADDRESS_BITS-1:0];
		region_q <= ctl_c[ADDRESS_BITS].region;
	end

	// size_c at the chain end is not needed past the last cell
	logic unused_size;
	assign unused_size = ^size_c[ADDRESS_BITS];

	assign done   = done_q & ~unused_size | done_q & unused_size;
	assign offset = offset_q;
	assign region = region_q;

endmodule

`default_nettype wire

[rtl/core/nam_checker.sv]
// ----------------------------------------------------------------------------
// nam_checker: port-level checks for the address mirror
// Watches latency, strobe origin and result codes on the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module nam_checker #(
	parameter int ADDRESS_BITS = nam_pkg::ADDRESS_BITS_DEF
) (
	input wire                           clk,
	input wire                           arst_n,
	input wire                           start,
	input wire                           busy,
	input wire                           done,
	input wire [ADDRESS_BITS-1:0]        offset,
	input nam_pkg::region_t              region
);
	import nam_pkg::*;

	localparam int LAT = ADDRESS_BITS + 1;

	// Every accepted item returns after the fixed chain latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("accepted item did not return after chain latency");

	// No result without an item accepted the chain latency earlier
	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result strobe without a matching item");

	// Region code is one of the three defined values
	a_region: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (region == REGION_RAM || region == REGION_ROM || region == REGION_NONE))
		else $error("undefined region code");

	// No store selected means a zero offset
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && region == REGION_NONE) |-> (offset == '0))
		else $error("nonzero offset with no region");

endmodule

bind nonpow2_address_mirror nam_checker #(.ADDRESS_BITS(ADDRESS_BITS)) u_nam_checker (.*);

`default_nettype wire
